// File: rtl/core/mbb_pkg.sv
// ----------------------------------------------------------------------------
// mbb_pkg: shared types and constants for the stereo modal biquad bank
// Delay word format, coefficient slot codes, multiplier operand split,
// mode weight table and delay word saturation.
// ----------------------------------------------------------------------------
package mbb_pkg;

	// delay words: signed, 24 fractional bits
	localparam int DLY_W     = 40;
	// shared multiplier operand A, split into two 24-bit halves
	localparam int OPA_W     = 48;
	localparam int OPA_SPLIT = 24;

	localparam int NUM_COEF = 5;
	localparam logic [2:0] SLOT_B0 = 3'd0;
	localparam logic [2:0] SLOT_B1 = 3'd1;
	localparam logic [2:0] SLOT_B2 = 3'd2;
	localparam logic [2:0] SLOT_A1 = 3'd3;
	localparam logic [2:0] SLOT_A2 = 3'd4;

	// widening switches on above this raw spread value
	localparam logic [12:0] SPREAD_ON = 13'd41;

	// round(65536 / (1 + 0.3*m)) in Q1.16, m = 0..15
	localparam logic [16:0] MODE_WEIGHT [16] = '{
		17'd65536, 17'd50412, 17'd40960, 17'd34493,
		17'd29789, 17'd26214, 17'd23406, 17'd21141,
		17'd19275, 17'd17712, 17'd16384, 17'd15241,
		17'd14247, 17'd13375, 17'd12603, 17'd11916
	};

	localparam logic signed [47:0] DLY_MAX = (48'sd1 <<< (DLY_W - 1)) - 48'sd1;
	localparam logic signed [47:0] DLY_MIN = -DLY_MAX - 48'sd1;

	typedef struct packed {
		logic signed [DLY_W-1:0] s0;
		logic signed [DLY_W-1:0] s1;
	} dly_row_t;

	typedef struct packed {
		logic       en;
		logic [3:0] filter;
		logic [2:0] slot;
	} coef_wr_t;

	typedef struct packed {
		logic issue;
		logic hi;
	} mac_ctl_t;

	function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [47:0] v);
		logic signed [DLY_W-1:0] r;
		if (v > DLY_MAX) begin
			r = DLY_MAX[DLY_W-1:0];
		end else if (v < DLY_MIN) begin
			r = DLY_MIN[DLY_W-1:0];
		end else begin
			r = v[DLY_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/mbb_if.sv
// ----------------------------------------------------------------------------
// mbb_if: valid/ready channels of the stereo modal biquad bank
// Input channel carries sample and coefficient-write items, output channel
// carries one stereo sample pair per sample item.
// ----------------------------------------------------------------------------
interface mbb_in_if #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 32
);
	logic                           valid;
	logic                           ready;
	logic                           action;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic [3:0]                     filter_index;
	logic [2:0]                     coef_slot;
	logic signed [COEF_WIDTH-1:0]   coef_value;

	modport source (
		output valid, action, sample, filter_index, coef_slot, coef_value,
		input  ready
	);
	modport sink (
		input  valid, action, sample, filter_index, coef_slot, coef_value,
		output ready
	);
endinterface

interface mbb_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] left_out;
	logic signed [SAMPLE_WIDTH-1:0] right_out;

	modport source (
		output valid, left_out, right_out,
		input  ready
	);
	modport sink (
		input  valid, left_out, right_out,
		output ready
	);
endinterface

// File: rtl/core/modal_biquad_bank_stereo.sv
// ----------------------------------------------------------------------------
// modal_biquad_bank_stereo: stereo modal resonator bank, 2 x NUM_MODES biquads
// A sample item gives its result once every filter, and the widening step when
// enabled, has run; the next item is taken only after that result is loaded.
// Each filter runs six products through the one shared multiplier, each one a
// coefficient read, two partial products, an add and an update, in that order.
// Coefficient-write items are taken only while idle and give no result.
// Reset clears spread, coefficients and delay words (via valid bits) at once.
// ----------------------------------------------------------------------------
module modal_biquad_bank_stereo #(
	parameter int NUM_MODES    = 8,
	parameter int SAMPLE_WIDTH = 16,
	parameter int COEF_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	mbb_in_if.sink      excite,
	mbb_out_if.source   result
);

	localparam int NFILT  = 2 * NUM_MODES;
	localparam int FI_W   = $clog2(NFILT);
	localparam int P_W    = mbb_pkg::OPA_W + COEF_WIDTH;
	localparam int CFRAC  = COEF_WIDTH - 4;
	localparam int XSHIFT = 25 - SAMPLE_WIDTH;
	localparam int FL_W   = 46;
	localparam int ACC_W  = 46;
	localparam int WID_W  = 64;
	localparam int DW     = mbb_pkg::DLY_W;

	localparam logic signed [WID_W-1:0] OUT_MAX =
		(64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
	localparam logic signed [WID_W-1:0] OUT_MIN = -OUT_MAX - 64'sd1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ADDR  = 7'b0000010,
		S_LO    = 7'b0000100,
		S_HI    = 7'b0001000,
		S_WAIT  = 7'b0010000,
		S_POST  = 7'b0100000,
		S_FINAL = 7'b1000000
	} state_t;

	typedef enum logic [2:0] {
		JOB_B0,
		JOB_B1,
		JOB_A1,
		JOB_B2,
		JOB_A2,
		JOB_WEIGHT,
		JOB_WIDEN
	} job_t;

	state_t                    state_q;
	job_t                      job_q;
	logic [FI_W-1:0]           f_q;
	logic [3:0]                m_q;
	logic [12:0]               spread_q;
	logic                      out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] left_q;
	logic signed [SAMPLE_WIDTH-1:0] right_q;

	logic signed [DW-1:0]      x_q;
	logic signed [DW-1:0]      y_q;
	logic signed [FL_W-1:0]    t_q;
	logic signed [DW-1:0]      s0n_q;
	logic signed [DW-1:0]      s1n_q;
	logic signed [WID_W-1:0]   sum_q;
	logic signed [ACC_W-1:0]   accl_q;
	logic signed [ACC_W-1:0]   accr_q;
	logic signed [WID_W-1:0]   lw_q;
	logic signed [WID_W-1:0]   rw_q;

	logic                      accept;
	logic                      final_load;
	logic                      last_mode;
	logic                      last_filter;
	logic                      widen_on;
	logic [15:0]               gain;

	mbb_pkg::mac_ctl_t         mac_ctl;
	logic signed [mbb_pkg::OPA_W-1:0] mac_a;
	logic signed [COEF_WIDTH-1:0] mac_b;
	logic signed [P_W-1:0]     mac_p;
	logic signed [P_W-1:0]     p_sh;
	logic signed [FL_W-1:0]    fl;
	logic signed [WID_W-1:0]   p64;
	logic signed [WID_W-1:0]   new_sum;
	logic signed [ACC_W-1:0]   new_acc;
	logic signed [WID_W-1:0]   mid;
	logic signed [WID_W-1:0]   wide_l;
	logic signed [WID_W-1:0]   wide_r;
	logic signed [mbb_pkg::OPA_W-1:0] diff;

	mbb_pkg::coef_wr_t         coef_wr;
	logic [2:0]                coef_slot;
	logic signed [COEF_WIDTH-1:0] coef_rd;
	mbb_pkg::dly_row_t         dly_rd;
	mbb_pkg::dly_row_t         dly_wr;

	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(
		input logic signed [WID_W-1:0] v
	);
		logic signed [SAMPLE_WIDTH-1:0] r;
		if (v > OUT_MAX) begin
			r = OUT_MAX[SAMPLE_WIDTH-1:0];
		end else if (v < OUT_MIN) begin
			r = OUT_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			r = v[SAMPLE_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic job_t next_job(input job_t j);
		job_t n;
		case (j)
			JOB_B0:  n = JOB_B1;
			JOB_B1:  n = JOB_A1;
			JOB_A1:  n = JOB_B2;
			JOB_B2:  n = JOB_A2;
			JOB_A2:  n = JOB_WEIGHT;
			default: n = JOB_WEIGHT;
		endcase
		return n;
	endfunction

	assign accept      = excite.valid && excite.ready;
	assign final_load  = (state_q == S_FINAL) && (!out_valid_q || result.ready);
	assign last_mode   = (m_q == 4'(NUM_MODES - 1));
	assign last_filter = (f_q == FI_W'(NFILT - 1));
	assign widen_on    = (spread_q > mbb_pkg::SPREAD_ON);
	assign gain = 16'd8192 + {3'b000, spread_q} + {2'b00, spread_q, 1'b0};

	assign excite.ready     = (state_q == S_IDLE);
	assign result.valid     = out_valid_q;
	assign result.left_out  = left_q;
	assign result.right_out = right_q;

	// ---- product post-processing
	assign p_sh    = mac_p >>> CFRAC;
	assign fl      = FL_W'(p_sh);
	assign p64     = WID_W'(mac_p);
	assign new_sum = sum_q + p64;
	assign new_acc = ACC_W'(new_sum >>> 18);
	assign diff    = mbb_pkg::OPA_W'(accl_q) - mbb_pkg::OPA_W'(accr_q);
	assign mid     = (WID_W'(accl_q) + WID_W'(accr_q)) <<< 13;
	assign wide_l  = (mid + p64) >>> 14;
	assign wide_r  = (mid - p64) >>> 14;

	// ---- operand selection for the shared multiplier
	always_comb begin
		case (job_q)
			JOB_B0, JOB_B1, JOB_B2: mac_a = mbb_pkg::OPA_W'(x_q);
			JOB_WIDEN:              mac_a = diff;
			default:                mac_a = mbb_pkg::OPA_W'(y_q);
		endcase
		case (job_q)
			JOB_WEIGHT: mac_b = COEF_WIDTH'(mbb_pkg::MODE_WEIGHT[m_q]);
			JOB_WIDEN:  mac_b = COEF_WIDTH'(gain);
			default:    mac_b = coef_rd;
		endcase
		case (job_q)
			JOB_B1:  coef_slot = mbb_pkg::SLOT_B1;
			JOB_A1:  coef_slot = mbb_pkg::SLOT_A1;
			JOB_B2:  coef_slot = mbb_pkg::SLOT_B2;
			JOB_A2:  coef_slot = mbb_pkg::SLOT_A2;
			default: coef_slot = mbb_pkg::SLOT_B0;
		endcase
	end

	assign mac_ctl.issue = (state_q == S_LO) || (state_q == S_HI);
	assign mac_ctl.hi    = (state_q == S_HI);

	assign coef_wr.en     = accept && excite.action;
	assign coef_wr.filter = excite.filter_index;
	assign coef_wr.slot   = excite.coef_slot;

	assign dly_wr.s0 = s0n_q;
	assign dly_wr.s1 = s1n_q;

	mbb_mac #(
		.B_W (COEF_WIDTH)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.a      (mac_a),
		.b      (mac_b),
		.prod   (mac_p)
	);

	mbb_coef_store #(
		.NUM_MODES  (NUM_MODES),
		.COEF_WIDTH (COEF_WIDTH)
	) u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (coef_wr),
		.wr_data   (excite.coef_value),
		.rd_en     (state_q == S_ADDR),
		.rd_filter (f_q),
		.rd_slot   (coef_slot),
		.rd_data   (coef_rd)
	);

	mbb_delay_store #(
		.NUM_MODES (NUM_MODES)
	) u_dly (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   ((state_q == S_POST) && (job_q == JOB_WEIGHT)),
		.wr_addr (f_q),
		.wr_row  (dly_wr),
		.rd_en   ((state_q == S_ADDR) && (job_q == JOB_B0)),
		.rd_addr (f_q),
		.rd_row  (dly_rd)
	);

	// ---- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			job_q       <= JOB_B0;
			f_q         <= '0;
			m_q         <= '0;
			spread_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				spread_q <= cfg_wdata;
			end
			if (final_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && !excite.action) begin
						job_q   <= JOB_B0;
						f_q     <= '0;
						m_q     <= '0;
						state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= S_LO;
				S_LO:   state_q <= S_HI;
				S_HI:   state_q <= S_WAIT;
				S_WAIT: state_q <= S_POST;
				S_POST: begin
					if (job_q == JOB_WIDEN) begin
						state_q <= S_FINAL;
					end else if (job_q == JOB_WEIGHT) begin
						if (last_filter) begin
							if (widen_on) begin
								job_q   <= JOB_WIDEN;
								state_q <= S_ADDR;
							end else begin
								state_q <= S_FINAL;
							end
						end else begin
							f_q     <= f_q + 1'b1;
							m_q     <= last_mode ? 4'd0 : m_q + 4'd1;
							job_q   <= JOB_B0;
							state_q <= S_ADDR;
						end
					end else begin
						job_q   <= next_job(job_q);
						state_q <= S_ADDR;
					end
				end
				S_FINAL: begin
					if (final_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- datapath registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && accept && !excite.action) begin
			x_q   <= DW'(excite.sample) <<< XSHIFT;
			sum_q <= '0;
		end
		if (state_q == S_POST) begin
			case (job_q)
				JOB_B0: y_q <= mbb_pkg::sat_dly(48'(fl) + 48'(dly_rd.s0));
				JOB_B1: t_q <= fl;
				JOB_A1: s0n_q <= mbb_pkg::sat_dly(48'(t_q) - 48'(fl) + 48'(dly_rd.s1));
				JOB_B2: t_q <= fl;
				JOB_A2: s1n_q <= mbb_pkg::sat_dly(48'(t_q) - 48'(fl));
				JOB_WEIGHT: begin
					if (last_mode) begin
						// close the channel: apply 0.25 and drop to 24 fraction bits
						sum_q <= '0;
						if (f_q < FI_W'(NUM_MODES)) begin
							accl_q <= new_acc;
						end else begin
							accr_q <= new_acc;
						end
						if (last_filter && !widen_on) begin
							lw_q <= WID_W'(accl_q);
							rw_q <= WID_W'(new_acc);
						end
					end else begin
						sum_q <= new_sum;
					end
				end
				JOB_WIDEN: begin
					lw_q <= wide_l;
					rw_q <= wide_r;
				end
				default: begin
					t_q <= t_q;
				end
			endcase
		end
		if (final_load) begin
			left_q  <= sat_out(lw_q >>> XSHIFT);
			right_q <= sat_out(rw_q >>> XSHIFT);
		end
	end

endmodule

// File: rtl/core/mbb_mac.sv
// ----------------------------------------------------------------------------
// mbb_mac: shared two-pass multiplier
// Forms a 48-bit by B_W-bit signed product from two partial products, low
// half first, with a register after the multiplier and an accumulator.
// ----------------------------------------------------------------------------
module mbb_mac #(
	parameter int B_W = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mbb_pkg::mac_ctl_t                    ctl,
	input  logic signed [mbb_pkg::OPA_W-1:0]     a,
	input  logic signed [B_W-1:0]                b,
	output logic signed [mbb_pkg::OPA_W+B_W-1:0] prod
);

	localparam int HALF_W = mbb_pkg::OPA_SPLIT + 1;
	localparam int PP_W   = HALF_W + B_W;
	localparam int P_W    = mbb_pkg::OPA_W + B_W;

	logic signed [HALF_W-1:0] half;
	logic signed [PP_W-1:0]   pp_s1;
	logic                     vld_s1;
	logic                     hi_s1;
	logic signed [P_W-1:0]    acc_q;

	// low half is taken unsigned, high half carries the sign
	assign half = ctl.hi
		? {a[mbb_pkg::OPA_W-1], a[mbb_pkg::OPA_W-1:mbb_pkg::OPA_SPLIT]}
		: {1'b0, a[mbb_pkg::OPA_SPLIT-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			hi_s1  <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			hi_s1  <= ctl.hi;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			pp_s1 <= half * b;
		end
		if (vld_s1) begin
			if (hi_s1) begin
				acc_q <= acc_q + (P_W'(pp_s1) <<< mbb_pkg::OPA_SPLIT);
			end else begin
				acc_q <= P_W'(pp_s1);
			end
		end
	end

	assign prod = acc_q;

endmodule

// File: rtl/core/mbb_coef_store.sv
// ----------------------------------------------------------------------------
// mbb_coef_store: biquad coefficient memory
// Five coefficients per filter, one write and one registered read a cycle.
// Entries never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module mbb_coef_store #(
	parameter int NUM_MODES  = 8,
	parameter int COEF_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mbb_pkg::coef_wr_t                     wr,
	input  logic signed [COEF_WIDTH-1:0]          wr_data,
	input  logic                                  rd_en,
	input  logic [$clog2(2*NUM_MODES)-1:0]        rd_filter,
	input  logic [2:0]                            rd_slot,
	output logic signed [COEF_WIDTH-1:0]          rd_data
);

	localparam int NFILT = 2 * NUM_MODES;
	localparam int DEPTH = NFILT * mbb_pkg::NUM_COEF;
	localparam int CA_W  = $clog2(DEPTH);

	logic signed [COEF_WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0]             vld_q;
	logic                         wr_ok;
	logic [CA_W-1:0]              wr_addr;
	logic [CA_W-1:0]              rd_addr;
	logic signed [COEF_WIDTH-1:0] rd_q;

	// drop writes to filters or slots that do not exist
	assign wr_ok = wr.en && ({2'b00, wr.filter} < 6'(NFILT))
		&& (wr.slot < 3'(mbb_pkg::NUM_COEF));
	assign wr_addr = CA_W'(wr.filter) * CA_W'(mbb_pkg::NUM_COEF) + CA_W'(wr.slot);
	assign rd_addr = CA_W'(rd_filter) * CA_W'(mbb_pkg::NUM_COEF) + CA_W'(rd_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/core/mbb_delay_store.sv
// ----------------------------------------------------------------------------
// mbb_delay_store: biquad delay word memory
// One row of two delay words per filter, registered read, row valid bits
// so that every filter starts from zero state after reset.
// ----------------------------------------------------------------------------
module mbb_delay_store #(
	parameter int NUM_MODES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [$clog2(2*NUM_MODES)-1:0] wr_addr,
	input  mbb_pkg::dly_row_t              wr_row,
	input  logic                           rd_en,
	input  logic [$clog2(2*NUM_MODES)-1:0] rd_addr,
	output mbb_pkg::dly_row_t              rd_row
);

	localparam int NFILT = 2 * NUM_MODES;

	mbb_pkg::dly_row_t mem [NFILT];
	logic [NFILT-1:0]  vld_q;
	mbb_pkg::dly_row_t rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_row = rd_q;

endmodule
